### rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, op and status codes for the round-robin task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int PID_BITS_DEF  = 16;

    localparam logic [3:0] OP_CREATE   = 4'd0;
    localparam logic [3:0] OP_SCHEDULE = 4'd1;
    localparam logic [3:0] OP_BLOCK    = 4'd2;
    localparam logic [3:0] OP_UNBLOCK  = 4'd3;
    localparam logic [3:0] OP_EXIT     = 4'd4;
    localparam logic [3:0] OP_LOCK     = 4'd5;
    localparam logic [3:0] OP_UNLOCK   = 4'd6;
    localparam logic [3:0] OP_QUERY    = 4'd7;
    localparam logic [3:0] OP_CLEANUP  = 4'd8;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_FULL        = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd2;
    localparam logic [2:0] ST_NOT_BLOCKED = 3'd3;
    localparam logic [2:0] ST_NOTHING     = 3'd4;
    localparam logic [2:0] ST_UNBALANCED  = 3'd5;

    localparam logic [3:0] TS_RUNNING = 4'd0;
    localparam logic [3:0] TS_READY   = 4'd1;
    localparam logic [3:0] TS_DEAD    = 4'd2;
    localparam logic [3:0] TS_BLOCKED = 4'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CUR_RD,
        S_CUR_CHK,
        S_SCHED,
        S_FIFO_RD,
        S_FIFO_WAIT,
        S_NEW_RD,
        S_NEW_WR,
        S_PID_RD,
        S_PID_WAIT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Task table with a round-robin ready queue, held in synchronous memories.
// ----------------------------------------------------------------------------
// One op item enters on the s_ channel and gives one result item on m_.
// s_axis_tdata: op[3:0], target_pid[19:4], block_reason[23:20].
// m_axis_tdata: status[2:0], result_pid[18:3], result_state[22:19],
// running_pid[38:23], switched[39].
// Items are handled one at a time. Slot pid and state live in one memory
// and the ready queue in another, both with registered read data; the
// current slot's pid and state are also held in registers.
// Create checks one used bit per cycle, up to the lowest free slot;
// unblock and query compare one slot pid per cycle; cleanup reads and
// checks each slot in turn; schedule, block and exit end early with an
// empty queue or while locked; an unlock that runs a postponed switch
// does what a schedule does. The next item is taken in the cycle after
// the result is accepted.
// Reset makes pid 0 in slot 0 running, with an empty queue; the pid/state
// memory itself needs no clearing since a used bit per slot gates it.
// While the receiver stalls, the result waits in the output register and
// s_axis_tready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int PID_BITS  = PID_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // op, target_pid, block_reason
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // status, result_pid, result_state,
                                        // running_pid, switched
);

    localparam int SW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int EW = PID_BITS + 4;

    state_t state_reg, state_next;

    logic [3:0]          op_reg, op_next;
    logic [15:0]         tpid_reg, tpid_next;
    logic [3:0]          reason_reg, reason_next;
    logic [MAX_TASKS-1:0] used_reg, used_next;
    logic [SW-1:0]       cur_reg, cur_next, old_reg, old_next;
    logic [SW-1:0]       head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [PID_BITS-1:0] npid_reg, npid_next, rpidc_reg, rpidc_next;
    logic [7:0]          depth_reg, depth_next;
    logic                post_reg, post_next;
    logic [SW-1:0]       idx_reg, idx_next, found_reg, found_next;
    logic                fnd_reg, fnd_next, last_reg, last_next;
    logic [3:0]          cst_reg, cst_next;
    logic [2:0]          status_reg, status_next;
    logic [15:0]         rpid_reg, rpid_next;
    logic [3:0]          rstate_reg, rstate_next;
    logic                mvalid_reg, mvalid_next;
    logic [39:0]         mdata_reg, mdata_next;
    logic                finalize;

    logic          tw_we;
    logic [SW-1:0] tw_wa, tw_ra;
    logic [EW-1:0] tw_wd, tw_rd;
    logic          fq_we;
    logic [SW-1:0] fq_wa, fq_ra;
    logic [SW-1:0] fq_wd, fq_rd;

    rrts_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_table (
        .aclk(aclk), .we(tw_we), .waddr(tw_wa), .wdata(tw_wd),
        .raddr(tw_ra), .rdata(tw_rd)
    );

    rrts_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_fifo (
        .aclk(aclk), .we(fq_we), .waddr(fq_wa), .wdata(fq_wd),
        .raddr(fq_ra), .rdata(fq_rd)
    );

    wire [PID_BITS-1:0] rd_pid = tw_rd[EW-1:4];
    wire [3:0]          rd_st  = tw_rd[3:0];
    wire [PID_BITS-1:0] tpid_m = PID_BITS >= 16 ? PID_BITS'(tpid_reg)
                                                : PID_BITS'(tpid_reg);

    function automatic logic [SW-1:0] wrap(input logic [SW-1:0] i);
        wrap = ({1'b0, i} + 1'b1 >= (SW+1)'(MAX_TASKS)) ? '0 : i + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            used_reg   <= MAX_TASKS'(1);
            cur_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            npid_reg   <= PID_BITS'(1);
            rpidc_reg  <= '0;
            depth_reg  <= '0;
            post_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            cst_reg    <= TS_RUNNING;
        end else begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            cur_reg    <= cur_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            npid_reg   <= npid_next;
            rpidc_reg  <= rpidc_next;
            depth_reg  <= depth_next;
            post_reg   <= post_next;
            mvalid_reg <= mvalid_next;
            cst_reg    <= cst_next;
        end
        op_reg     <= op_next;
        tpid_reg   <= tpid_next;
        reason_reg <= reason_next;
        old_reg    <= old_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        fnd_reg    <= fnd_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        rpid_reg   <= rpid_next;
        rstate_reg <= rstate_next;
        mdata_reg  <= mdata_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        tpid_next   = tpid_reg;
        reason_next = reason_reg;
        used_next   = used_reg;
        cur_next    = cur_reg;
        old_next    = old_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        npid_next   = npid_reg;
        rpidc_next  = rpidc_reg;
        depth_next  = depth_reg;
        post_next   = post_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        fnd_next    = fnd_reg;
        last_next   = last_reg;
        cst_next    = cst_reg;
        status_next = status_reg;
        rpid_next   = rpid_reg;
        rstate_next = rstate_reg;
        mdata_next  = mdata_reg;
        mvalid_next = mvalid_reg && !m_axis_tready;
        finalize    = 1'b0;
        tw_we = 1'b0; tw_wa = cur_reg; tw_wd = '0; tw_ra = cur_reg;
        fq_we = 1'b0; fq_wa = tail_reg; fq_wd = '0; fq_ra = head_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    op_next     = s_axis_tdata[3:0];
                    tpid_next   = s_axis_tdata[19:4];
                    reason_next = s_axis_tdata[23:20];
                    old_next    = cur_reg;
                    status_next = ST_OK;
                    rpid_next   = '0;
                    rstate_next = '0;
                    idx_next    = '0;
                    fnd_next    = 1'b0;
                    case (s_axis_tdata[3:0])
                        OP_CREATE: begin
                            state_next = S_NEW_RD;
                        end
                        OP_SCHEDULE: begin
                            state_next = S_SCHED;
                        end
                        OP_BLOCK: begin
                            tw_we = 1'b1;
                            tw_wd = {rpidc_reg, (s_axis_tdata[23:20] < TS_BLOCKED)
                                     ? TS_BLOCKED : s_axis_tdata[23:20]};
                            cst_next = tw_wd[3:0];
                            state_next = S_SCHED;
                        end
                        OP_EXIT: begin
                            tw_we = 1'b1;
                            tw_wd = {rpidc_reg, TS_DEAD};
                            cst_next = TS_DEAD;
                            state_next = S_SCHED;
                        end
                        OP_UNBLOCK, OP_QUERY: begin
                            state_next = S_CUR_RD;
                        end
                        OP_LOCK: begin
                            if (depth_reg == 8'hFF) status_next = ST_UNBALANCED;
                            else depth_next = depth_reg + 8'd1;
                            state_next = S_DONE;
                        end
                        OP_UNLOCK: begin
                            state_next = S_DONE;
                            if (depth_reg == 8'd0) begin
                                status_next = ST_UNBALANCED;
                            end else begin
                                depth_next = depth_reg - 8'd1;
                                if (depth_reg == 8'd1 && post_reg) begin
                                    post_next  = 1'b0;
                                    state_next = S_SCHED;
                                end
                            end
                        end
                        OP_CLEANUP: begin
                            state_next = S_SCAN_RD;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCHED: begin
                if (depth_reg != 8'd0) begin
                    post_next  = 1'b1;
                    state_next = S_DONE;
                end else if (count_reg == '0) begin
                    if (op_reg != OP_UNLOCK) status_next = ST_NOTHING;
                    state_next = S_DONE;
                end else begin
                    fq_ra      = head_reg;
                    head_next  = wrap(head_reg);
                    count_next = count_reg - 1'b1;
                    state_next = S_FIFO_WAIT;
                end
            end
            S_FIFO_WAIT: begin
                if (cst_reg == TS_RUNNING || cst_reg == TS_READY) begin
                    tw_we = 1'b1;
                    tw_wd = {rpidc_reg, TS_READY};
                    fq_we = 1'b1; fq_wa = tail_reg; fq_wd = cur_reg;
                    tail_next  = wrap(tail_reg);
                    count_next = count_reg + 1'b1;
                end
                tw_ra      = fq_rd;
                cur_next   = fq_rd;
                state_next = S_FIFO_RD;
            end
            S_FIFO_RD: begin
                tw_we      = 1'b1; tw_wa = cur_reg;
                tw_wd      = {rd_pid, TS_RUNNING};
                rpidc_next = rd_pid;
                cst_next   = TS_RUNNING;
                state_next = S_DONE;
            end
            S_NEW_RD: begin
                // find lowest free slot via used bits, one per cycle
                if (!used_reg[idx_reg]) begin
                    tw_we = 1'b1; tw_wa = idx_reg;
                    tw_wd = {npid_reg, TS_READY};
                    used_next[idx_reg] = 1'b1;
                    rpid_next  = 16'(npid_reg);
                    npid_next  = npid_reg + 1'b1;
                    fq_we = 1'b1; fq_wa = tail_reg; fq_wd = idx_reg;
                    tail_next  = wrap(tail_reg);
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end else if ({1'b0, idx_reg} == (SW+1)'(MAX_TASKS - 1)) begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CUR_RD: begin
                tw_ra = cur_reg;
                if (used_reg[cur_reg] && rpidc_reg == tpid_m) begin
                    fnd_next   = 1'b1;
                    found_next = cur_reg;
                    state_next = S_PID_WAIT;
                end else begin
                    tw_ra      = '0;
                    state_next = S_PID_RD;
                end
            end
            S_PID_RD: begin
                // current slot already checked from its registers
                if (used_reg[idx_reg] && idx_reg != cur_reg && rd_pid == tpid_m) begin
                    fnd_next   = 1'b1;
                    found_next = idx_reg;
                    state_next = S_PID_WAIT;
                    tw_ra      = idx_reg;
                end else if ({1'b0, idx_reg} == (SW+1)'(MAX_TASKS - 1)) begin
                    state_next = S_PID_WAIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    tw_ra    = idx_reg + 1'b1;
                end
            end
            S_PID_WAIT: begin
                tw_ra = found_reg;
                state_next = S_CUR_CHK;
            end
            S_CUR_CHK: begin
                state_next = S_DONE;
                if (op_reg == OP_QUERY) rpid_next = tpid_reg;
                if (!fnd_reg) begin
                    status_next = ST_NOT_FOUND;
                end else if (op_reg == OP_QUERY) begin
                    rstate_next = (found_reg == cur_reg) ? cst_reg : rd_st;
                end else if (((found_reg == cur_reg) ? cst_reg : rd_st) < TS_BLOCKED) begin
                    status_next = ST_NOT_BLOCKED;
                end else if (found_reg == cur_reg) begin
                    tw_we = 1'b1; tw_wa = cur_reg;
                    tw_wd = {rpidc_reg, TS_RUNNING};
                    cst_next = TS_RUNNING;
                end else begin
                    tw_we = 1'b1; tw_wa = found_reg;
                    tw_wd = {rd_pid, TS_READY};
                    fq_we = 1'b1; fq_wa = tail_reg; fq_wd = found_reg;
                    tail_next  = wrap(tail_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            S_SCAN_RD: begin
                tw_ra      = idx_reg;
                last_next  = ({1'b0, idx_reg} == (SW+1)'(MAX_TASKS - 1));
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (used_reg[idx_reg] && rd_st == TS_DEAD && idx_reg != cur_reg) begin
                    used_next[idx_reg] = 1'b0;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = last_reg ? S_DONE : S_SCAN_RD;
            end
            S_NEW_WR: state_next = S_DONE;
            S_DONE: begin
                finalize = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase

        if (finalize) begin
            mvalid_next = 1'b1;
            mdata_next  = {(old_reg != cur_reg), 16'(rpidc_reg), rstate_reg,
                           rpid_reg, status_reg};
            state_next  = S_IDLE;
        end
    end

endmodule

`default_nettype wire

### rtl/rrts_ram.sv
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### dv/tb_round_robin_task_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_round_robin_task_scheduler
// Self-checking bench for the round-robin task scheduler. A directed table
// covers reset state, table full and errors; lock nesting to saturation
// and random op sequences follow, all checked against a behavioral task-table model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_round_robin_task_scheduler;
    import rrts_pkg::*;

    localparam int NSLOT = 16;

    typedef struct packed {
        logic        switched;
        logic [15:0] running_pid;
        logic [3:0]  result_state;
        logic [15:0] result_pid;
        logic [2:0]  status;
    } sched_result_t;

    typedef struct {
        logic [3:0]  op;
        logic [15:0] tpid;
        logic [3:0]  reason;
        bit          fixed;
        logic [2:0]  status;
    } op_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [39:0] m_axis_tdata;

    round_robin_task_scheduler u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #2 aclk = ~aclk;

    // task table model
    logic [15:0] t_pid [NSLOT];
    logic [3:0]  t_state [NSLOT];
    bit          t_used [NSLOT];
    logic [3:0]  rq [NSLOT];
    int          rq_head, rq_tail, rq_count;
    int          cur_slot;
    logic [15:0] pid_next;
    int          lock_level;
    bit          sw_pending;

    sched_result_t pending_results[$];
    bit            fixed_q[$];
    logic [2:0]    fixed_status_q[$];
    int errors = 0, n_results = 0, n_switches = 0;
    int n_sent = 0;
    int hold_cycles = 0;
    bit quiet_rx = 1'b0;
    bit quiet_tx = 1'b0;

    function automatic void table_reset();
        for (int i = 0; i < NSLOT; i++) begin
            t_pid[i] = '0; t_state[i] = '0; t_used[i] = 1'b0; rq[i] = '0;
        end
        t_used[0] = 1'b1; t_state[0] = TS_RUNNING;
        rq_head = 0; rq_tail = 0; rq_count = 0; cur_slot = 0;
        pid_next = 16'd1; lock_level = 0; sw_pending = 1'b0;
    endfunction

    function automatic void rq_push(int s);
        if (rq_count >= NSLOT) return;
        rq[rq_tail] = s[3:0];
        rq_tail = (rq_tail + 1) % NSLOT;
        rq_count++;
    endfunction

    function automatic logic [2:0] run_schedule();
        int nxt;
        if (lock_level != 0) begin
            sw_pending = 1'b1;
            return ST_OK;
        end
        if (rq_count == 0) return ST_NOTHING;
        nxt = rq[rq_head];
        rq_head = (rq_head + 1) % NSLOT;
        rq_count--;
        if (t_state[cur_slot] == TS_RUNNING || t_state[cur_slot] == TS_READY) begin
            t_state[cur_slot] = TS_READY;
            rq_push(cur_slot);
        end
        cur_slot = nxt;
        t_state[nxt] = TS_RUNNING;
        return ST_OK;
    endfunction

    function automatic int lookup_pid(logic [15:0] p);
        if (t_used[cur_slot] && t_pid[cur_slot] == p) return cur_slot;
        for (int i = 0; i < NSLOT; i++)
            if (t_used[i] && t_pid[i] == p) return i;
        return -1;
    endfunction

    function automatic sched_result_t apply_op(logic [3:0] op, logic [15:0] tpid,
                                               logic [3:0] reason);
        sched_result_t r;
        int old_slot, s;
        r = '0;
        old_slot = cur_slot;
        case (op)
            OP_CREATE: begin
                s = -1;
                for (int i = NSLOT - 1; i >= 0; i--) if (!t_used[i]) s = i;
                if (s < 0) r.status = ST_FULL;
                else begin
                    t_used[s] = 1'b1; t_pid[s] = pid_next; t_state[s] = TS_READY;
                    r.result_pid = pid_next;
                    pid_next = pid_next + 16'd1;
                    rq_push(s);
                end
            end
            OP_SCHEDULE: r.status = run_schedule();
            OP_BLOCK: begin
                t_state[cur_slot] = (reason < TS_BLOCKED) ? TS_BLOCKED : reason;
                r.status = run_schedule();
            end
            OP_UNBLOCK: begin
                s = lookup_pid(tpid);
                if (s < 0) r.status = ST_NOT_FOUND;
                else if (t_state[s] < TS_BLOCKED) r.status = ST_NOT_BLOCKED;
                else if (s == cur_slot) t_state[s] = TS_RUNNING;
                else begin
                    t_state[s] = TS_READY;
                    rq_push(s);
                end
            end
            OP_EXIT: begin
                t_state[cur_slot] = TS_DEAD;
                r.status = run_schedule();
            end
            OP_LOCK: begin
                if (lock_level == 255) r.status = ST_UNBALANCED;
                else lock_level++;
            end
            OP_UNLOCK: begin
                if (lock_level == 0) r.status = ST_UNBALANCED;
                else begin
                    lock_level--;
                    if (lock_level == 0 && sw_pending) begin
                        sw_pending = 1'b0;
                        void'(run_schedule());
                    end
                end
            end
            OP_QUERY: begin
                r.result_pid = tpid;
                s = lookup_pid(tpid);
                if (s < 0) r.status = ST_NOT_FOUND;
                else r.result_state = t_state[s];
            end
            OP_CLEANUP: begin
                for (int i = 0; i < NSLOT; i++)
                    if (t_used[i] && t_state[i] == TS_DEAD && i != cur_slot) begin
                        t_used[i] = 1'b0; t_state[i] = '0; t_pid[i] = '0;
                    end
            end
            default: ;
        endcase
        r.running_pid = t_pid[cur_slot];
        r.switched = (old_slot != cur_slot);
        return r;
    endfunction

    // sender, tvalid may drop between items unless quiet_tx is set
    task automatic send_op(logic [3:0] op, logic [15:0] tpid, logic [3:0] reason,
                           bit fixed, logic [2:0] st);
        while (!quiet_tx && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {reason, tpid, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_results.push_back(apply_op(op, tpid, reason));
        fixed_q.push_back(fixed);
        fixed_status_q.push_back(st);
        n_sent++;
    endtask

    function automatic logic [15:0] pick_pid();
        int k;
        k = $urandom_range(9);
        if (k < 6) begin
            int s;
            s = $urandom_range(NSLOT - 1);
            return t_pid[s];
        end
        if (k < 8) return pid_next - 16'($urandom_range(1, 40));
        return 16'($urandom);
    endfunction

    // receiver
    always @(posedge aclk) begin
        sched_result_t got, want;
        if (aresetn) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end else
                m_axis_tready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 28);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                n_results++;
                if (got.switched) n_switches++;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected item %h", m_axis_tdata);
                end else begin
                    want = pending_results.pop_front();
                    if (fixed_q.pop_front() && want.status != fixed_status_q[0]) begin
                        errors++;
                        if (errors <= 10)
                            $display("table status %0d model %0d",
                                     fixed_status_q[0], want.status);
                    end
                    void'(fixed_status_q.pop_front());
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("item %0d: exp st=%0d pid=%h rs=%0d run=%h sw=%0d",
                                n_results, want.status, want.result_pid,
                                want.result_state, want.running_pid, want.switched);
                            $display("item %0d: got st=%0d pid=%h rs=%0d run=%h sw=%0d",
                                n_results, got.status, got.result_pid,
                                got.result_state, got.running_pid, got.switched);
                        end
                    end
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    op_row_t directed[$];

    function automatic void add_row(logic [3:0] op, logic [15:0] p, logic [3:0] rsn,
                                    bit fixed = 1'b0, logic [2:0] st = ST_OK);
        op_row_t r;
        r.op = op; r.tpid = p; r.reason = rsn; r.fixed = fixed; r.status = st;
        directed.push_back(r);
    endfunction

    initial begin
        int k;
        table_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(OP_QUERY, 16'd0, 4'd0, 1'b1, ST_OK);
        add_row(OP_SCHEDULE, 16'd0, 4'd0, 1'b1, ST_NOTHING);
        add_row(OP_UNLOCK, 16'd0, 4'd0, 1'b1, ST_UNBALANCED);
        add_row(OP_UNBLOCK, 16'hFFFF, 4'd0, 1'b1, ST_NOT_FOUND);
        add_row(OP_UNBLOCK, 16'd0, 4'd0, 1'b1, ST_NOT_BLOCKED);
        add_row(OP_BLOCK, 16'd0, 4'd0, 1'b1, ST_NOTHING);
        add_row(OP_UNBLOCK, 16'd0, 4'd15);
        for (int i = 0; i < 16; i++) add_row(OP_CREATE, 16'd0, 4'd0);
        add_row(OP_LOCK, 16'd0, 4'd0);
        add_row(OP_SCHEDULE, 16'd0, 4'd0);
        add_row(OP_UNLOCK, 16'd0, 4'd0);
        add_row(OP_BLOCK, 16'd0, 4'd15);
        add_row(OP_EXIT, 16'd0, 4'd0);
        add_row(OP_CLEANUP, 16'd0, 4'd0);
        add_row(4'd15, 16'hFFFF, 4'd15);
        foreach (directed[i])
            send_op(directed[i].op, directed[i].tpid, directed[i].reason,
                    directed[i].fixed, directed[i].status);

        // lock saturation
        for (int i = 0; i < 256; i++) send_op(OP_LOCK, '0, '0, 1'b0, ST_OK);
        for (int i = 0; i < 256; i++) send_op(OP_UNLOCK, '0, '0, 1'b0, ST_OK);

        for (int n = 0; n < 200; n++) begin
            if (n == 40) hold_cycles = 400;
            if (n == 100) begin
                s_axis_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                repeat (40) @(posedge aclk);
            end
            quiet_rx = (n >= 130 && n < 170);
            quiet_tx = quiet_rx;
            k = $urandom_range(99);
            if (k < 14) send_op(OP_CREATE, 16'($urandom), 4'($urandom), 1'b0, ST_OK);
            else if (k < 30) send_op(OP_SCHEDULE, 16'($urandom), 4'($urandom), 1'b0, ST_OK);
            else if (k < 40) send_op(OP_BLOCK, '0, 4'($urandom), 1'b0, ST_OK);
            else if (k < 55) send_op(OP_UNBLOCK, pick_pid(), 4'($urandom), 1'b0, ST_OK);
            else if (k < 62) send_op(OP_EXIT, '0, '0, 1'b0, ST_OK);
            else if (k < 69) send_op(OP_LOCK, '0, '0, 1'b0, ST_OK);
            else if (k < 77) send_op(OP_UNLOCK, '0, '0, 1'b0, ST_OK);
            else if (k < 89) send_op(OP_QUERY, pick_pid(), 4'($urandom), 1'b0, ST_OK);
            else if (k < 96) send_op(OP_CLEANUP, '0, '0, 1'b0, ST_OK);
            else send_op(4'($urandom_range(9, 15)), 16'($urandom), 4'($urandom),
                         1'b0, ST_OK);
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(posedge aclk);
        $display("%0d ops sent, %0d results checked, %0d task switches seen",
                 n_sent, n_results, n_switches);
        $display("ran a full table, lock nesting to saturation and mixed random ops");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
